### rtl/ucdp_pkg.sv
// Shared types and constants for the USB configuration descriptor parser.
`default_nettype none
package ucdp_pkg;

    localparam int CAP_DEPTH = 9;

    localparam logic [7:0] DESC_TYPE_CONFIG    = 8'd2;
    localparam logic [7:0] DESC_TYPE_INTERFACE = 8'd4;
    localparam logic [7:0] DESC_TYPE_ENDPOINT  = 8'd5;

    typedef enum logic [3:0] {
        KIND_CONFIG      = 4'd0,
        KIND_INTERFACE   = 4'd1,
        KIND_ENDPOINT    = 4'd2,
        KIND_END         = 4'd3,
        KIND_BAD_TYPE    = 4'd4,
        KIND_MANY_IFACES = 4'd5,
        KIND_MANY_EPS    = 4'd6,
        KIND_ZERO_LENGTH = 4'd7,
        KIND_ORPHAN_EP   = 4'd8
    } kind_t;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
    } in_word_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  iface_slot;
        logic [7:0]  ep_slot;
        logic [7:0]  field_a;
        logic [7:0]  field_b;
        logic [15:0] field_c;
        logic [7:0]  field_d;
        logic [7:0]  field_e;
        logic [7:0]  field_f;
        logic [7:0]  field_g;
        logic        done;
    } rec_t;

endpackage
`default_nettype wire

### rtl/usb_config_descriptor_parser.sv
// Top level of the USB configuration descriptor parser.
// A byte is registered in the input stage on acceptance and decoded into the result register
// when the walker steps, which waits while the result register is stalled and not taken.
// Throughput is one byte per cycle while the result register is not stalled.
// A stalled result register holds the input stage, which then holds one more word.
// Reset clears all walk state and both stages; no clearing pass is needed.
`default_nettype none
module usb_config_descriptor_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  byte_in,
    input  wire logic        first,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [3:0]       record_kind,
    output logic [7:0]       iface_slot,
    output logic [7:0]       ep_slot,
    output logic [7:0]       field_a,
    output logic [7:0]       field_b,
    output logic [15:0]      field_c,
    output logic [7:0]       field_d,
    output logic [7:0]       field_e,
    output logic [7:0]       field_f,
    output logic [7:0]       field_g,
    output logic             done_res
);
    import ucdp_pkg::*;

    logic     word_valid;
    in_word_t word;
    logic     step;
    logic     out_free;
    logic     res_valid;
    rec_t     res;
    rec_t     rec;

    assign step = word_valid && out_free;

    ucdp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .byte_in    (byte_in),
        .first      (first),
        .step       (step),
        .word_valid (word_valid),
        .word       (word)
    );

    ucdp_walker u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .word      (word),
        .res_valid (res_valid),
        .res       (res)
    );

    ucdp_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .res_valid (res_valid),
        .res       (res),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_free  (out_free),
        .rec       (rec)
    );

    assign record_kind = rec.kind;
    assign iface_slot  = rec.iface_slot;
    assign ep_slot     = rec.ep_slot;
    assign field_a     = rec.field_a;
    assign field_b     = rec.field_b;
    assign field_c     = rec.field_c;
    assign field_d     = rec.field_d;
    assign field_e     = rec.field_e;
    assign field_f     = rec.field_f;
    assign field_g     = rec.field_g;
    assign done_res    = rec.done;

endmodule
`default_nettype wire

### rtl/ucdp_in_stage.sv
// Input register that holds one accepted descriptor byte until the walker takes it.
`default_nettype none
module ucdp_in_stage (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [7:0]         byte_in,
    input  wire logic               first,
    input  wire logic               step,
    output logic                    word_valid,
    output ucdp_pkg::in_word_t      word
);
    import ucdp_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_word_t word_reg;

    assign in_ready   = !valid_reg || step;
    assign word_valid = valid_reg;
    assign word       = word_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (step)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            word_reg.data  <= byte_in;
            word_reg.first <= first;
        end
    end

endmodule
`default_nettype wire

### rtl/ucdp_walker.sv
// Descriptor walk state and the per-byte decode that forms one record.
`default_nettype none
module ucdp_walker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire ucdp_pkg::in_word_t word,
    output logic                    res_valid,
    output ucdp_pkg::rec_t          res
);
    import ucdp_pkg::*;

    logic        active_reg, active_next;
    logic [15:0] total_reg, total_next;
    logic [15:0] seen_reg, seen_next;
    logic [7:0]  off_reg, off_next;
    logic [7:0]  dlen_reg, dlen_next;
    logic [7:0]  dtype_reg, dtype_next;
    logic [7:0]  cap_reg [CAP_DEPTH];
    logic [7:0]  cap_next [CAP_DEPTH];
    logic [7:0]  icount_reg, icount_next;
    logic [7:0]  epcount_reg, epcount_next;
    logic [7:0]  nif_reg, nif_next;
    logic [7:0]  neps_reg, neps_next;
    logic        seen_if_reg, seen_if_next;

    logic        e_active;
    logic [15:0] e_total;
    logic [15:0] e_seen;
    logic [7:0]  e_off;
    logic [7:0]  e_icount;
    logic [7:0]  e_epcount;
    logic [7:0]  e_nif;
    logic [7:0]  e_neps;
    logic        e_seen_if;
    logic        hdr;
    logic        done;
    logic [15:0] seen_inc;
    logic [15:0] hdr_total;

    always_comb
    begin
        // A first byte restarts from the cleared state.
        e_active  = word.first || active_reg;
        e_total   = word.first ? 16'd0 : total_reg;
        e_seen    = word.first ? 16'd0 : seen_reg;
        e_off     = word.first ? 8'd0 : off_reg;
        e_icount  = word.first ? 8'd0 : icount_reg;
        e_epcount = word.first ? 8'd0 : epcount_reg;
        e_nif     = word.first ? 8'd0 : nif_reg;
        e_neps    = word.first ? 8'd0 : neps_reg;
        e_seen_if = word.first ? 1'b0 : seen_if_reg;

        active_next  = e_active;
        total_next   = e_total;
        seen_next    = e_seen;
        off_next     = e_off;
        dlen_next    = word.first ? 8'd0 : dlen_reg;
        dtype_next   = word.first ? 8'd0 : dtype_reg;
        icount_next  = e_icount;
        epcount_next = e_epcount;
        nif_next     = e_nif;
        neps_next    = e_neps;
        seen_if_next = e_seen_if;
        for (int i = 0; i < CAP_DEPTH; i++)
        begin
            cap_next[i] = word.first ? 8'd0 : cap_reg[i];
        end

        hdr       = (e_seen == {8'h00, e_off});
        seen_inc  = (e_seen == 16'hFFFF) ? e_seen : e_seen + 16'd1;
        hdr_total = 16'h0000;
        done      = 1'b0;
        res_valid = 1'b0;
        res       = '0;
        res.kind  = KIND_CONFIG;

        if (e_active)
        begin
            if (e_off == 8'd0)
            begin
                for (int i = 0; i < CAP_DEPTH; i++)
                begin
                    cap_next[i] = 8'd0;
                end
                dlen_next  = word.data;
                dtype_next = 8'd0;
            end
            if (e_off == 8'd1)
            begin
                dtype_next = word.data;
            end
            for (int i = 0; i < CAP_DEPTH; i++)
            begin
                if (e_off == 8'(i))
                begin
                    cap_next[i] = word.data;
                end
            end

            if (e_off == 8'd0 && word.data == 8'd0)
            begin
                res_valid   = 1'b1;
                res.kind    = KIND_ZERO_LENGTH;
                res.done    = 1'b1;
                active_next = 1'b0;
            end
            else
            begin
                seen_next = seen_inc;
                if ({1'b0, e_off} + 9'd1 < {1'b0, dlen_next})
                begin
                    off_next = e_off + 8'd1;
                end
                else
                begin
                    off_next = 8'd0;
                    if (hdr)
                    begin
                        hdr_total  = {cap_next[3], cap_next[2]};
                        total_next = hdr_total;
                        res_valid  = 1'b1;
                        if (dtype_next != DESC_TYPE_CONFIG)
                        begin
                            res.kind    = KIND_BAD_TYPE;
                            res.done    = 1'b1;
                            active_next = 1'b0;
                        end
                        else
                        begin
                            nif_next    = cap_next[4];
                            done        = seen_inc >= hdr_total;
                            res.kind    = KIND_CONFIG;
                            res.field_a = cap_next[4];
                            res.field_b = cap_next[5];
                            res.field_c = {8'h00, cap_next[6]};
                            res.field_d = cap_next[7];
                            res.field_e = cap_next[8];
                            res.done    = done;
                            active_next = !done;
                        end
                    end
                    else
                    begin
                        done = seen_inc >= e_total;
                        if (dtype_next == DESC_TYPE_INTERFACE)
                        begin
                            res_valid = 1'b1;
                            if (e_icount >= e_nif)
                            begin
                                res.kind    = KIND_MANY_IFACES;
                                res.done    = 1'b1;
                                active_next = 1'b0;
                            end
                            else
                            begin
                                neps_next      = cap_next[4];
                                icount_next    = e_icount + 8'd1;
                                epcount_next   = 8'd0;
                                seen_if_next   = 1'b1;
                                res.kind       = KIND_INTERFACE;
                                res.iface_slot = e_icount;
                                res.field_a    = cap_next[2];
                                res.field_b    = cap_next[3];
                                res.field_c    = {8'h00, cap_next[4]};
                                res.field_d    = cap_next[5];
                                res.field_e    = cap_next[6];
                                res.field_f    = cap_next[7];
                                res.field_g    = cap_next[8];
                                res.done       = done;
                                active_next    = !done;
                            end
                        end
                        else if (dtype_next == DESC_TYPE_ENDPOINT)
                        begin
                            res_valid = 1'b1;
                            if (!e_seen_if)
                            begin
                                res.kind    = KIND_ORPHAN_EP;
                                res.done    = 1'b1;
                                active_next = 1'b0;
                            end
                            else if (e_epcount >= e_neps)
                            begin
                                res.kind    = KIND_MANY_EPS;
                                res.done    = 1'b1;
                                active_next = 1'b0;
                            end
                            else
                            begin
                                epcount_next   = e_epcount + 8'd1;
                                res.kind       = KIND_ENDPOINT;
                                res.iface_slot = e_icount - 8'd1;
                                res.ep_slot    = e_epcount;
                                res.field_a    = cap_next[2];
                                res.field_b    = cap_next[3];
                                res.field_c    = {cap_next[5], cap_next[4]};
                                res.field_d    = cap_next[6];
                                res.done       = done;
                                active_next    = !done;
                            end
                        end
                        else if (done)
                        begin
                            res_valid   = 1'b1;
                            res.kind    = KIND_END;
                            res.done    = 1'b1;
                            active_next = 1'b0;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            total_reg   <= 16'd0;
            seen_reg    <= 16'd0;
            off_reg     <= 8'd0;
            dlen_reg    <= 8'd0;
            dtype_reg   <= 8'd0;
            icount_reg  <= 8'd0;
            epcount_reg <= 8'd0;
            nif_reg     <= 8'd0;
            neps_reg    <= 8'd0;
            seen_if_reg <= 1'b0;
            for (int i = 0; i < CAP_DEPTH; i++)
            begin
                cap_reg[i] <= 8'd0;
            end
        end
        else if (step)
        begin
            active_reg  <= active_next;
            total_reg   <= total_next;
            seen_reg    <= seen_next;
            off_reg     <= off_next;
            dlen_reg    <= dlen_next;
            dtype_reg   <= dtype_next;
            icount_reg  <= icount_next;
            epcount_reg <= epcount_next;
            nif_reg     <= nif_next;
            neps_reg    <= neps_next;
            seen_if_reg <= seen_if_next;
            for (int i = 0; i < CAP_DEPTH; i++)
            begin
                cap_reg[i] <= cap_next[i];
            end
        end
    end

endmodule
`default_nettype wire

### rtl/ucdp_out_stage.sv
// Result register that holds one record until the downstream side takes it.
`default_nettype none
module ucdp_out_stage (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire logic               res_valid,
    input  wire ucdp_pkg::rec_t     res,
    input  wire logic               out_ready,
    output logic                    out_valid,
    output logic                    out_free,
    output ucdp_pkg::rec_t          rec
);
    import ucdp_pkg::*;

    logic valid_reg;
    logic valid_next;
    rec_t rec_reg;

    assign out_valid = valid_reg;
    assign out_free  = !valid_reg || out_ready;
    assign rec       = rec_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (step)
        begin
            valid_next = res_valid;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && res_valid)
        begin
            rec_reg <= res;
        end
    end

endmodule
`default_nettype wire

### tb/tb_usb_config_descriptor_parser.sv
// Self-checking testbench for the USB configuration descriptor parser.
`timescale 1ns / 1ps

module tb_usb_config_descriptor_parser;
    import ucdp_pkg::*;

    localparam int STALL_LIMIT = 1000;

    typedef struct {
        logic [7:0] data;
        logic       start;
        bit         typed;
        kind_t      want_kind;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  byte_in;
    logic        first;
    logic        out_valid;
    logic        out_ready;
    logic [3:0]  record_kind;
    logic [7:0]  iface_slot;
    logic [7:0]  ep_slot;
    logic [7:0]  field_a;
    logic [7:0]  field_b;
    logic [15:0] field_c;
    logic [7:0]  field_d;
    logic [7:0]  field_e;
    logic [7:0]  field_f;
    logic [7:0]  field_g;
    logic        done_res;

    // Walk state of the predictor.
    bit          walk_on = 1'b0;
    logic [15:0] set_len = '0;
    logic [15:0] seen_cnt = '0;
    logic [7:0]  d_off = '0;
    logic [7:0]  d_len = '0;
    logic [7:0]  d_type = '0;
    logic [7:0]  cap [CAP_DEPTH];
    logic [7:0]  if_cnt = '0;
    logic [7:0]  ep_cnt = '0;
    logic [7:0]  if_limit = '0;
    logic [7:0]  ep_limit = '0;
    bit          if_seen = 1'b0;

    rec_t        pending_records [$];
    logic [7:0]  set_stream [$];
    int          mismatches = 0;
    int          stall_cycles = 0;
    bit          tx_calm = 1'b0;
    bit          rx_calm = 1'b0;

    // Idle byte, restart into a zero length, bad header types, a header that
    // ends the set at once, then a short header followed by an orphan endpoint.
    dir_row_t dir_rows [24] = '{
        '{8'h12, 1'b0, 1'b0, KIND_CONFIG},
        '{8'h09, 1'b1, 1'b0, KIND_CONFIG},
        '{8'h02, 1'b0, 1'b0, KIND_CONFIG},
        '{8'h00, 1'b1, 1'b1, KIND_ZERO_LENGTH},
        '{8'h03, 1'b1, 1'b0, KIND_CONFIG},
        '{8'h07, 1'b0, 1'b0, KIND_CONFIG},
        '{8'h00, 1'b0, 1'b1, KIND_BAD_TYPE},
        '{8'h01, 1'b1, 1'b1, KIND_BAD_TYPE},
        '{8'h04, 1'b1, 1'b0, KIND_CONFIG},
        '{8'h02, 1'b0, 1'b0, KIND_CONFIG},
        '{8'h00, 1'b0, 1'b0, KIND_CONFIG},
        '{8'h00, 1'b0, 1'b0, KIND_CONFIG},
        '{8'h05, 1'b1, 1'b0, KIND_CONFIG},
        '{8'h02, 1'b0, 1'b0, KIND_CONFIG},
        '{8'h0C, 1'b0, 1'b0, KIND_CONFIG},
        '{8'h00, 1'b0, 1'b0, KIND_CONFIG},
        '{8'hFF, 1'b0, 1'b0, KIND_CONFIG},
        '{8'h07, 1'b0, 1'b0, KIND_CONFIG},
        '{8'h05, 1'b0, 1'b0, KIND_CONFIG},
        '{8'h81, 1'b0, 1'b0, KIND_CONFIG},
        '{8'h03, 1'b0, 1'b0, KIND_CONFIG},
        '{8'hFF, 1'b0, 1'b0, KIND_CONFIG},
        '{8'hFF, 1'b0, 1'b0, KIND_CONFIG},
        '{8'h0A, 1'b0, 1'b1, KIND_ORPHAN_EP}
    };

    usb_config_descriptor_parser u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .byte_in     (byte_in),
        .first       (first),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .record_kind (record_kind),
        .iface_slot  (iface_slot),
        .ep_slot     (ep_slot),
        .field_a     (field_a),
        .field_b     (field_b),
        .field_c     (field_c),
        .field_d     (field_d),
        .field_e     (field_e),
        .field_f     (field_f),
        .field_g     (field_g),
        .done_res    (done_res)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic rec_t fault_record(kind_t k);
        rec_t r;
        r = '0;
        r.kind = k;
        r.done = 1'b1;
        return r;
    endfunction

    function automatic bit walk_descriptor_byte(input logic [7:0] data, input logic start,
                                                output rec_t rec);
        logic [7:0] o;
        bit at_hdr;
        bit hit;
        rec = '0;
        hit = 1'b0;
        if (start)
        begin
            walk_on = 1'b1;
            set_len = '0;
            seen_cnt = '0;
            d_off = '0;
            d_len = '0;
            d_type = '0;
            foreach (cap[i]) cap[i] = '0;
            if_cnt = '0;
            ep_cnt = '0;
            if_limit = '0;
            ep_limit = '0;
            if_seen = 1'b0;
        end
        if (!walk_on)
            return 1'b0;
        o = d_off;
        at_hdr = (seen_cnt == {8'd0, o});
        if (o == 8'd0)
        begin
            foreach (cap[i]) cap[i] = '0;
            d_len = data;
            d_type = '0;
        end
        if (o == 8'd0 && data == 8'd0)
        begin
            rec = fault_record(KIND_ZERO_LENGTH);
            hit = 1'b1;
        end
        else
        begin
            if (o == 8'd1)
                d_type = data;
            if (o < CAP_DEPTH)
                cap[o[3:0]] = data;
            if (seen_cnt != 16'hFFFF)
                seen_cnt++;
            if ({1'b0, o} + 9'd1 < {1'b0, d_len})
                d_off = o + 8'd1;
            else
            begin
                d_off = '0;
                hit = 1'b1;
                if (at_hdr)
                begin
                    set_len = {cap[3], cap[2]};
                    if (d_type != DESC_TYPE_CONFIG)
                        rec = fault_record(KIND_BAD_TYPE);
                    else
                    begin
                        if_limit = cap[4];
                        rec.kind = KIND_CONFIG;
                        rec.field_a = cap[4];
                        rec.field_b = cap[5];
                        rec.field_c = {8'd0, cap[6]};
                        rec.field_d = cap[7];
                        rec.field_e = cap[8];
                        rec.done = (seen_cnt >= set_len);
                    end
                end
                else if (d_type == DESC_TYPE_INTERFACE)
                begin
                    if (if_cnt >= if_limit)
                        rec = fault_record(KIND_MANY_IFACES);
                    else
                    begin
                        rec.kind = KIND_INTERFACE;
                        rec.iface_slot = if_cnt;
                        rec.field_a = cap[2];
                        rec.field_b = cap[3];
                        rec.field_c = {8'd0, cap[4]};
                        rec.field_d = cap[5];
                        rec.field_e = cap[6];
                        rec.field_f = cap[7];
                        rec.field_g = cap[8];
                        rec.done = (seen_cnt >= set_len);
                        ep_limit = cap[4];
                        if_cnt++;
                        ep_cnt = '0;
                        if_seen = 1'b1;
                    end
                end
                else if (d_type == DESC_TYPE_ENDPOINT)
                begin
                    if (!if_seen)
                        rec = fault_record(KIND_ORPHAN_EP);
                    else if (ep_cnt >= ep_limit)
                        rec = fault_record(KIND_MANY_EPS);
                    else
                    begin
                        rec.kind = KIND_ENDPOINT;
                        rec.iface_slot = if_cnt - 8'd1;
                        rec.ep_slot = ep_cnt;
                        rec.field_a = cap[2];
                        rec.field_b = cap[3];
                        rec.field_c = {cap[5], cap[4]};
                        rec.field_d = cap[6];
                        rec.done = (seen_cnt >= set_len);
                        ep_cnt++;
                    end
                end
                else if (seen_cnt >= set_len)
                begin
                    rec.kind = KIND_END;
                    rec.done = 1'b1;
                end
                else
                    hit = 1'b0;
            end
        end
        if (hit && rec.done)
            walk_on = 1'b0;
        return hit;
    endfunction

    task automatic send_byte(input logic [7:0] data, input logic start, input bit typed,
                             input kind_t want_kind);
        rec_t rec;
        bit hit;
        byte_in <= data;
        first <= start;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        hit = walk_descriptor_byte(data, start, rec);
        if (typed)
            pending_records.push_back(fault_record(want_kind));
        else if (hit)
            pending_records.push_back(rec);
    endtask

    task automatic pace_sender();
        if (!tx_calm && $urandom_range(0, 9) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    task automatic put_desc(input int len, input logic [7:0] dtype, input logic [7:0] cnt);
        for (int k = 0; k < len; k++)
        begin
            if (k == 0)
                set_stream.push_back(len[7:0]);
            else if (k == 1)
                set_stream.push_back(dtype);
            else if (k == 4)
                set_stream.push_back(cnt);
            else
                set_stream.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    function automatic int pick_len(int nominal);
        return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 12) : nominal;
    endfunction

    task automatic build_set();
        int n_if;
        int n_ep;
        int hlen;
        int cut;
        logic [15:0] tl;
        set_stream.delete();
        n_if = $urandom_range(0, 3);
        hlen = pick_len(9);
        put_desc(hlen,
                 ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255)) : DESC_TYPE_CONFIG,
                 8'(n_if));
        if ($urandom_range(0, 11) == 0)
            put_desc(7, DESC_TYPE_ENDPOINT, 8'($urandom_range(0, 255)));
        for (int i = 0; i < n_if + ($urandom_range(0, 9) == 0); i++)
        begin
            if ($urandom_range(0, 4) == 0)
                put_desc($urandom_range(2, 12), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)));
            if ($urandom_range(0, 29) == 0)
                set_stream.push_back(8'd0);
            n_ep = $urandom_range(0, 3);
            put_desc(pick_len(9), DESC_TYPE_INTERFACE, 8'(n_ep));
            for (int j = 0; j < n_ep + ($urandom_range(0, 9) == 0); j++)
                put_desc(pick_len(7), DESC_TYPE_ENDPOINT, 8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 2) == 0)
            put_desc($urandom_range(2, 12), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
        tl = 16'(set_stream.size());
        if ($urandom_range(0, 7) == 0)
            tl = 16'($urandom_range(0, set_stream.size() + 20));
        if (hlen > 2)
            set_stream[2] = tl[7:0];
        if (hlen > 3)
            set_stream[3] = tl[15:8];
        if ($urandom_range(0, 15) == 0)
        begin
            cut = $urandom_range(1, set_stream.size());
            set_stream = set_stream[0:cut-1];
        end
    endtask

    task automatic send_set();
        foreach (set_stream[i])
        begin
            pace_sender();
            send_byte(set_stream[i], i == 0, 1'b0, KIND_CONFIG);
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t mismatch %s: expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        rec_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_records.size() == 0)
            begin
                mismatches++;
                $display("%0t unexpected record: expected none, actual kind %0h",
                         $time, record_kind);
            end
            else
            begin
                want = pending_records.pop_front();
                check_field("record_kind", 16'(want.kind), 16'(record_kind));
                check_field("iface_slot", 16'(want.iface_slot), 16'(iface_slot));
                check_field("ep_slot", 16'(want.ep_slot), 16'(ep_slot));
                check_field("field_a", 16'(want.field_a), 16'(field_a));
                check_field("field_b", 16'(want.field_b), 16'(field_b));
                check_field("field_c", want.field_c, field_c);
                check_field("field_d", 16'(want.field_d), 16'(field_d));
                check_field("field_e", 16'(want.field_e), 16'(field_e));
                check_field("field_f", 16'(want.field_f), 16'(field_f));
                check_field("field_g", 16'(want.field_g), 16'(field_g));
                check_field("done_res", 16'(want.done), 16'(done_res));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        out_ready = 1'b0;
        while (!rst_n) @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (!rx_calm && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    initial
    begin
        int sent;
        int set_idx;
        rst_n = 1'b0;
        in_valid = 1'b0;
        byte_in = '0;
        first = 1'b0;
        foreach (cap[i]) cap[i] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            pace_sender();
            send_byte(dir_rows[i].data, dir_rows[i].start, dir_rows[i].typed,
                      dir_rows[i].want_kind);
        end

        sent = 0;
        set_idx = 0;
        while (sent < 1200)
        begin
            tx_calm = ($urandom_range(0, 4) == 0);
            rx_calm = ($urandom_range(0, 4) == 0);
            build_set();
            send_set();
            sent += set_stream.size();
            if ($urandom_range(0, 5) == 0)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    pace_sender();
                    send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, KIND_CONFIG);
                end
            end
            // On every seventh set, hold the next set back until every record of this one has been taken.
            if (set_idx % 7 == 3)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (pending_records.size() != 0) @(posedge clk);
            end
            set_idx++;
        end

        tx_calm = 1'b1;
        rx_calm = 1'b1;
        repeat (3)
        begin
            build_set();
            send_set();
        end

        in_valid <= 1'b0;
        while (pending_records.size() != 0) @(posedge clk);
        repeat (12) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
